/* design/jsu_pkg.sv */
package jsu_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam int CP_W   = 21;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_ESC_END = 3'd1,
    ERR_BAD_U   = 3'd2,
    ERR_BAD_ESC = 3'd3,
    ERR_STR_END = 3'd4
  } err_t;

  // one decoded text byte: an optional code point to encode, then an optional single result
  typedef struct packed {
    logic            has_cp;
    logic [CP_W-1:0] cp;
    logic            has_tail;
    kind_t           tail_kind;
    logic [7:0]      tail_byte;
    err_t            tail_err;
  } entry_t;

endpackage

/* design/jsu_front.sv */
module jsu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            text_valid,
  input  logic [7:0]      text_byte,
  input  logic            text_end,
  output logic            text_stall,
  output logic            push,
  output jsu_pkg::entry_t entry,
  input  logic            full
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  localparam logic [15:0] HIGH_LO = 16'hD800;
  localparam logic [15:0] HIGH_HI = 16'hDBFF;
  localparam logic [15:0] LOW_LO = 16'hDC00;
  localparam logic [15:0] LOW_HI = 16'hDFFF;
  localparam logic [CP_W-1:0] CP_REPLACE = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_PLANE1 = 21'h010000;

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_HEX,
    MODE_HELD,
    MODE_HELD_ESC,
    MODE_LOW_HEX
  } mode_t;

  mode_t       mode, mode_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [9:0]  held_high, held_high_next;
  logic        accept;
  logic [4:0]  hexv;
  logic [8:0]  escv;
  logic [15:0] acc_full;
  logic        has_entry;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [8:0] esc_value(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      CH_QUOTE:  r = {1'b1, 8'h22};
      CH_BSLASH: r = {1'b1, 8'h5C};
      CH_SLASH:  r = {1'b1, 8'h2F};
      CH_B:      r = {1'b1, 8'h08};
      CH_F:      r = {1'b1, 8'h0C};
      CH_N:      r = {1'b1, 8'h0A};
      CH_R:      r = {1'b1, 8'h0D};
      CH_T:      r = {1'b1, 8'h09};
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

  assign text_stall = full;
  assign accept = text_valid && !full;
  assign hexv = hex_digit(text_byte);
  assign escv = esc_value(text_byte);
  assign acc_full = {hex_accum[11:0], hexv[3:0]};
  assign has_entry = entry.has_cp || entry.has_tail;
  assign push = accept && has_entry;

  always_comb begin
    mode_next = mode;
    hex_accum_next = hex_accum;
    digit_count_next = digit_count;
    held_high_next = held_high;
    entry = '0;
    entry.tail_kind = KIND_DATA;
    entry.tail_err = ERR_NONE;
    if (text_end) begin
      mode_next = MODE_PLAIN;
      hex_accum_next = '0;
      digit_count_next = '0;
      held_high_next = '0;
      entry.has_tail = 1'b1;
      entry.tail_kind = KIND_ERR;
      unique case (mode)
        MODE_ESC: entry.tail_err = ERR_ESC_END;
        MODE_HEX, MODE_LOW_HEX: entry.tail_err = ERR_BAD_U;
        MODE_HELD: begin
          entry.has_cp = 1'b1;
          entry.cp = CP_REPLACE;
          entry.tail_err = ERR_STR_END;
        end
        MODE_HELD_ESC: begin
          entry.has_cp = 1'b1;
          entry.cp = CP_REPLACE;
          entry.tail_err = ERR_ESC_END;
        end
        default: entry.tail_err = ERR_STR_END;
      endcase
    end else begin
      unique case (mode)
        MODE_ESC, MODE_HELD_ESC: begin
          mode_next = MODE_PLAIN;
          if (mode == MODE_HELD_ESC && text_byte != CH_U) begin
            entry.has_cp = 1'b1;
            entry.cp = CP_REPLACE;
            held_high_next = '0;
          end
          if (text_byte == CH_U) begin
            mode_next = (mode == MODE_HELD_ESC) ? MODE_LOW_HEX : MODE_HEX;
            hex_accum_next = '0;
            digit_count_next = '0;
          end else if (escv[8]) begin
            entry.has_tail = 1'b1;
            entry.tail_byte = escv[7:0];
          end else begin
            entry.has_tail = 1'b1;
            entry.tail_kind = KIND_ERR;
            entry.tail_err = ERR_BAD_ESC;
            hex_accum_next = '0;
            digit_count_next = '0;
            held_high_next = '0;
          end
        end
        MODE_HEX, MODE_LOW_HEX: begin
          if (!hexv[4]) begin
            mode_next = MODE_PLAIN;
            hex_accum_next = '0;
            digit_count_next = '0;
            held_high_next = '0;
            entry.has_tail = 1'b1;
            entry.tail_kind = KIND_ERR;
            entry.tail_err = ERR_BAD_U;
          end else if (digit_count == 2'd3) begin
            mode_next = MODE_PLAIN;
            hex_accum_next = '0;
            digit_count_next = '0;
            entry.has_cp = 1'b1;
            if (mode == MODE_LOW_HEX) begin
              held_high_next = '0;
              if (acc_full >= LOW_LO && acc_full <= LOW_HI) begin
                entry.cp = CP_PLANE1 + {1'b0, held_high, acc_full[9:0]};
              end else begin
                entry.cp = CP_REPLACE;
              end
            end else if (acc_full >= HIGH_LO && acc_full <= HIGH_HI) begin
              entry.has_cp = 1'b0;
              held_high_next = acc_full[9:0];
              mode_next = MODE_HELD;
            end else if (acc_full >= LOW_LO && acc_full <= LOW_HI) begin
              entry.cp = CP_REPLACE;
            end else begin
              entry.cp = {5'd0, acc_full};
            end
          end else begin
            hex_accum_next = acc_full;
            digit_count_next = digit_count + 2'd1;
          end
        end
        default: begin
          // plain, or a high half waiting, whether or not an escape follows
          if (mode == MODE_HELD && text_byte != CH_BSLASH) begin
            entry.has_cp = 1'b1;
            entry.cp = CP_REPLACE;
            held_high_next = '0;
          end
          if (text_byte == CH_BSLASH) begin
            mode_next = (mode == MODE_HELD) ? MODE_HELD_ESC : MODE_ESC;
          end else if (text_byte == CH_QUOTE) begin
            mode_next = MODE_PLAIN;
            hex_accum_next = '0;
            digit_count_next = '0;
            held_high_next = '0;
            entry.has_tail = 1'b1;
            entry.tail_kind = KIND_DONE;
          end else begin
            mode_next = MODE_PLAIN;
            entry.has_tail = 1'b1;
            entry.tail_byte = text_byte;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
      hex_accum <= '0;
      digit_count <= '0;
      held_high <= '0;
    end else if (accept) begin
      mode <= mode_next;
      hex_accum <= hex_accum_next;
      digit_count <= digit_count_next;
      held_high <= held_high_next;
    end
  end

endmodule

/* design/jsu_fifo.sv */
module jsu_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jsu_pkg::entry_t wdata,
  input  logic            pop,
  output logic            full,
  output logic            nonempty,
  output jsu_pkg::entry_t rdata
);
  import jsu_pkg::*;

  entry_t         slots [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QCW-1:0] count;

  assign full = (count == QCW'(QDEPTH));
  assign nonempty = (count != '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QAW'(1);
      end
      if (pop) begin
        rptr <= rptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

/* design/jsu_back.sv */
module jsu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  jsu_pkg::entry_t entry,
  output logic            pop,
  output logic            result_valid,
  input  logic            result_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      result_kind,
  output logic [2:0]      error_code,
  output logic            last
);
  import jsu_pkg::*;

  localparam logic [7:0] UTF8_CONT = 8'h80;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [CP_W-1:0] CP_TWO = 21'h000080;
  localparam logic [CP_W-1:0] CP_THREE = 21'h000800;
  localparam logic [CP_W-1:0] CP_FOUR = 21'h010000;

  logic [1:0] idx;
  logic [1:0] lenm1;
  logic [2:0] cp_len;
  logic [2:0] total;
  logic       at_cp;
  logic       step_last;
  logic       load;
  logic [7:0] cp_byte;

  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                           input logic [1:0] len_m1,
                                           input logic [1:0] pos);
    logic [7:0] r;
    logic [1:0] shift;
    shift = len_m1 - pos;
    if (pos == 2'd0) begin
      unique case (len_m1)
        2'd0: r = cp[7:0];
        2'd1: r = UTF8_LEAD2 | {3'd0, cp[10:6]};
        2'd2: r = UTF8_LEAD3 | {4'd0, cp[15:12]};
        default: r = UTF8_LEAD4 | {5'd0, cp[20:18]};
      endcase
    end else begin
      unique case (shift)
        2'd1: r = UTF8_CONT | {2'd0, cp[11:6]};
        2'd2: r = UTF8_CONT | {2'd0, cp[17:12]};
        default: r = UTF8_CONT | {2'd0, cp[5:0]};
      endcase
    end
    return r;
  endfunction

  always_comb begin
    if (entry.cp < CP_TWO) begin
      lenm1 = 2'd0;
    end else if (entry.cp < CP_THREE) begin
      lenm1 = 2'd1;
    end else if (entry.cp < CP_FOUR) begin
      lenm1 = 2'd2;
    end else begin
      lenm1 = 2'd3;
    end
  end

  assign cp_len = entry.has_cp ? {1'b0, lenm1} + 3'd1 : 3'd0;
  assign total = cp_len + {2'd0, entry.has_tail};
  assign at_cp = {1'b0, idx} < cp_len;
  assign step_last = ({1'b0, idx} + 3'd1) == total;
  assign load = q_valid && (!result_valid || !result_stall);
  assign pop = load && step_last;
  assign cp_byte = utf8_byte(entry.cp, lenm1, idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx <= '0;
    end else if (load) begin
      result_valid <= 1'b1;
      idx <= step_last ? 2'd0 : idx + 2'd1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= at_cp ? cp_byte : entry.tail_byte;
      result_kind <= at_cp ? KIND_DATA : entry.tail_kind;
      error_code <= at_cp ? ERR_NONE : entry.tail_err;
      last <= step_last;
    end
  end

endmodule

/* design/json_string_unescape_utf8.sv */
// Decodes a JSON string body into UTF-8, one text byte per transaction and one result per
// transaction on the output side. A text byte is taken every cycle unless the four-entry queue
// between the escape decoder and the UTF-8 encoder is full; the encoder sends one result a
// cycle while result_stall is low, so a \u escape that yields up to four bytes, or a dropped
// surrogate followed by another result, holds it until all are sent; text_stall rises only
// once the queue has filled. A result is registered in the queue and at the encoder output.
// Error and finish results always carry last; the decoder is in its plain state after either.
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  input  logic       text_end,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic [1:0] result_kind,
  output logic [2:0] error_code,
  output logic       last
);
  import jsu_pkg::*;

  entry_t push_entry;
  entry_t head_entry;
  logic   push;
  logic   pop;
  logic   full;
  logic   nonempty;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_byte  (text_byte),
    .text_end   (text_end),
    .text_stall (text_stall),
    .push       (push),
    .entry      (push_entry),
    .full       (full)
  );

  jsu_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (push_entry),
    .pop      (pop),
    .full     (full),
    .nonempty (nonempty),
    .rdata    (head_entry)
  );

  jsu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (nonempty),
    .entry        (head_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .result_kind  (result_kind),
    .error_code   (error_code),
    .last         (last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && !nonempty))
    else $error("queue read while empty");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind != KIND_DATA) |-> last)
    else $error("finish or error result not marked last");

  a_error_code_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result_kind == KIND_ERR) == (error_code != ERR_NONE)))
    else $error("error code does not match result kind");

endmodule

/* sim/json_string_unescape_utf8_tb.sv */
`timescale 1ns / 100ps

module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  localparam logic [7:0]  CH_QUOTE       = 8'h22;
  localparam logic [7:0]  CH_BSLASH      = 8'h5C;
  localparam logic [7:0]  CH_U           = 8'h75;
  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_SUPPLEMENT  = 21'h010000;
  localparam logic [15:0] HIGH_FIRST     = 16'hD800;
  localparam logic [15:0] HIGH_LAST      = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST      = 16'hDC00;
  localparam logic [15:0] LOW_LAST       = 16'hDFFF;
  localparam int          N_RANDOM       = 210;
  localparam int          SETTLE_CYCLES  = 20;
  localparam int          RUN_LIMIT_NS   = 400000;

  typedef enum logic [2:0] {
    ST_PLAIN,
    ST_ESC,
    ST_HEX,
    ST_HELD,
    ST_HELD_ESC,
    ST_LOW_HEX
  } dec_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       drain;
  } text_item_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    err_t       err;
    logic       lst;
  } utf8_result_t;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       text_valid   = 1'b0;
  logic [7:0] text_byte    = 8'h00;
  logic       text_end     = 1'b0;
  logic       result_stall = 1'b0;
  logic       text_stall;
  logic       result_valid;
  logic [7:0] out_byte;
  logic [1:0] result_kind;
  logic [2:0] error_code;
  logic       last;

  json_string_unescape_utf8 u_dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .text_end     (text_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .result_kind  (result_kind),
    .error_code   (error_code),
    .last         (last)
  );

  text_item_t   text_queue[$];
  utf8_result_t decoded_due[$];
  utf8_result_t step_out[$];
  utf8_result_t want;
  logic         drain_next = 1'b0;
  logic         text_taken = 1'b0;
  int           fail_count = 0;
  int           gap_left   = 0;
  int           burst_left = 0;
  int           rx_mode    = 0;
  logic [5:0]   rx_phase   = 6'd0;

  dec_state_t  dstate    = ST_PLAIN;
  logic [15:0] hex_acc   = 16'h0000;
  logic [1:0]  ndig      = 2'd0;
  logic [15:0] high_half = 16'h0000;

  initial begin
    forever #1 clk = ~clk;
  end

  // decoder prediction

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    if (c >= "a" && c <= "f") return 5'(c - 8'h57);
    if (c >= "A" && c <= "F") return 5'(c - 8'h37);
    return 5'd16;
  endfunction

  function automatic void emit(input logic [7:0] b, input kind_t k, input err_t e);
    utf8_result_t r;
    r.data = b;
    r.kind = k;
    r.err  = e;
    r.lst  = 1'b0;
    step_out = {step_out, r};
  endfunction

  function automatic void emit_cp(input logic [20:0] cp);
    if (cp < 21'h80) begin
      emit(cp[7:0], KIND_DATA, ERR_NONE);
    end else if (cp < 21'h800) begin
      emit({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
      emit({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end else if (cp < CP_SUPPLEMENT) begin
      emit({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
      emit({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
      emit({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end else begin
      emit({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
      emit({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
      emit({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
      emit({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end
  endfunction

  function automatic void clear_dec();
    dstate    = ST_PLAIN;
    hex_acc   = 16'h0000;
    ndig      = 2'd0;
    high_half = 16'h0000;
  endfunction

  function automatic void plain_char(input logic [7:0] c);
    if (c == CH_QUOTE) begin
      clear_dec();
      emit(8'h00, KIND_DONE, ERR_NONE);
    end else if (c == CH_BSLASH) begin
      dstate = ST_ESC;
    end else begin
      emit(c, KIND_DATA, ERR_NONE);
    end
  endfunction

  function automatic void escape_char(input logic [7:0] c);
    logic [7:0] v;
    logic       ok;
    dstate = ST_PLAIN;
    ok     = 1'b1;
    v      = 8'h00;
    case (c)
      CH_QUOTE:  v = CH_QUOTE;
      CH_BSLASH: v = CH_BSLASH;
      "/":       v = 8'h2F;
      "b":       v = 8'h08;
      "f":       v = 8'h0C;
      "n":       v = 8'h0A;
      "r":       v = 8'h0D;
      "t":       v = 8'h09;
      default:   ok = 1'b0;
    endcase
    if (c == CH_U) begin
      dstate  = ST_HEX;
      hex_acc = 16'h0000;
      ndig    = 2'd0;
    end else if (ok) begin
      emit(v, KIND_DATA, ERR_NONE);
    end else begin
      clear_dec();
      emit(8'h00, KIND_ERR, ERR_BAD_ESC);
    end
  endfunction

  function automatic void finish_hex(input logic second);
    logic [15:0] cp;
    logic [15:0] hi;
    cp      = hex_acc;
    hex_acc = 16'h0000;
    ndig    = 2'd0;
    dstate  = ST_PLAIN;
    if (second) begin
      hi        = high_half;
      high_half = 16'h0000;
      if (cp >= LOW_FIRST && cp <= LOW_LAST && hi >= HIGH_FIRST && hi <= HIGH_LAST)
        emit_cp(CP_SUPPLEMENT + {1'b0, hi[9:0], cp[9:0]});
      else
        emit_cp(CP_REPLACEMENT);
    end else if (cp >= HIGH_FIRST && cp <= HIGH_LAST) begin
      high_half = cp;
      dstate    = ST_HELD;
    end else if (cp >= LOW_FIRST && cp <= LOW_LAST) begin
      emit_cp(CP_REPLACEMENT);
    end else begin
      emit_cp({5'd0, cp});
    end
  endfunction

  function automatic void decode_text(input logic [7:0] c, input logic fin);
    utf8_result_t r;
    logic [4:0]   nib;
    step_out.delete();
    if (fin) begin
      case (dstate)
        ST_ESC:             emit(8'h00, KIND_ERR, ERR_ESC_END);
        ST_HEX, ST_LOW_HEX: emit(8'h00, KIND_ERR, ERR_BAD_U);
        ST_HELD: begin
          emit_cp(CP_REPLACEMENT);
          emit(8'h00, KIND_ERR, ERR_STR_END);
        end
        ST_HELD_ESC: begin
          emit_cp(CP_REPLACEMENT);
          emit(8'h00, KIND_ERR, ERR_ESC_END);
        end
        default:            emit(8'h00, KIND_ERR, ERR_STR_END);
      endcase
      clear_dec();
    end else begin
      case (dstate)
        ST_ESC: escape_char(c);
        ST_HEX, ST_LOW_HEX: begin
          nib = nibble_of(c);
          if (nib[4]) begin
            clear_dec();
            emit(8'h00, KIND_ERR, ERR_BAD_U);
          end else begin
            hex_acc = {hex_acc[11:0], nib[3:0]};
            if (ndig == 2'd3) finish_hex(dstate == ST_LOW_HEX);
            else ndig = ndig + 2'd1;
          end
        end
        ST_HELD: begin
          if (c == CH_BSLASH) begin
            dstate = ST_HELD_ESC;
          end else begin
            high_half = 16'h0000;
            dstate    = ST_PLAIN;
            emit_cp(CP_REPLACEMENT);
            plain_char(c);
          end
        end
        ST_HELD_ESC: begin
          if (c == CH_U) begin
            dstate  = ST_LOW_HEX;
            hex_acc = 16'h0000;
            ndig    = 2'd0;
          end else begin
            high_half = 16'h0000;
            emit_cp(CP_REPLACEMENT);
            escape_char(c);
          end
        end
        default: plain_char(c);
      endcase
    end
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.lst = 1'b1;
      step_out = {step_out, r};
    end
    decoded_due = {decoded_due, step_out};
  endfunction

  // text generation

  task automatic queue_text(input logic [7:0] c, input logic fin = 1'b0);
    text_item_t t;
    t.ch    = c;
    t.fin   = fin;
    t.drain = drain_next;
    drain_next = 1'b0;
    text_queue = {text_queue, t};
  endtask

  function automatic logic [7:0] hex_ch(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic logic is_escape_char(input logic [7:0] c);
    case (c)
      CH_QUOTE, CH_BSLASH, CH_U, "/", "b", "f", "n", "r", "t": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] simple_escape();
    case ($urandom_range(0, 7))
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return "/";
      3:       return "b";
      4:       return "f";
      5:       return "n";
      6:       return "r";
      default: return "t";
    endcase
  endfunction

  function automatic logic [7:0] bad_escape();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_escape_char(b));
    return b;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    logic [4:0] nib;
    do begin
      b   = 8'($urandom_range(0, 255));
      nib = nibble_of(b);
    end while (!nib[4]);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return CH_U;
      3:       return hex_ch(4'($urandom_range(0, 15)));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_u(input logic [15:0] v);
    queue_text(CH_BSLASH);
    queue_text(CH_U);
    for (int i = 3; i >= 0; i--) queue_text(hex_ch(v[4*i +: 4]));
  endtask

  task automatic queue_partial_u();
    queue_text(CH_BSLASH);
    queue_text(CH_U);
    repeat ($urandom_range(0, 3)) queue_text(hex_ch(4'($urandom_range(0, 15))));
  endtask

  function automatic logic [15:0] random_high();
    return HIGH_FIRST + 16'($urandom_range(0, 1023));
  endfunction

  function automatic logic [15:0] random_low();
    return LOW_FIRST + 16'($urandom_range(0, 1023));
  endfunction

  task automatic queue_after_high();
    logic [7:0]  b;
    logic [15:0] v;
    case ($urandom_range(0, 4))
      0: begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE || b == CH_BSLASH) b[0] = ~b[0];
        queue_text(b);
      end
      1: queue_text(CH_QUOTE);
      2: begin
        queue_text(CH_BSLASH);
        queue_text(simple_escape());
      end
      3: begin
        v = 16'($urandom_range(0, 16'hFFFF));
        if (v >= LOW_FIRST && v <= LOW_LAST) v[13] = ~v[13];
        queue_u(v);
      end
      default: begin
        queue_text(CH_BSLASH);
        queue_text(bad_escape());
      end
    endcase
  endtask

  task automatic load_directed();
    queue_text(8'h00);
    queue_text(8'hFF);
    queue_text(CH_BSLASH);
    queue_text("n");
    queue_text(CH_BSLASH);
    queue_text(CH_U);
    queue_text("F");
    queue_text("f");
    queue_text("F");
    queue_text("f");
    queue_text(CH_BSLASH);
    queue_text("x");
    queue_text(CH_BSLASH);
    queue_text(CH_U);
    queue_text("D");
    queue_text("B");
    queue_text("F");
    queue_text("F");
    queue_text(8'hA5, 1'b1);
    queue_text(CH_BSLASH);
    queue_text(8'h5A, 1'b1);
    queue_text(CH_QUOTE);
    queue_text(8'h00, 1'b1);
  endtask

  task automatic load_random();
    int         stop;
    int         pick;
    logic       mid_done;
    logic [7:0] b;
    stop       = text_queue.size() + N_RANDOM;
    mid_done   = 1'b0;
    drain_next = 1'b1;
    while (text_queue.size() < stop) begin
      if (!mid_done && text_queue.size() >= stop - N_RANDOM / 2) begin
        drain_next = 1'b1;
        mid_done   = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 24) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE || b == CH_BSLASH) b[0] = ~b[0];
        queue_text(b);
      end else if (pick < 34) begin
        queue_text(CH_BSLASH);
        queue_text(simple_escape());
      end else if (pick < 48) begin
        case ($urandom_range(0, 2))
          0:       queue_u(16'($urandom_range(0, 16'h007F)));
          1:       queue_u(16'($urandom_range(16'h0080, 16'h07FF)));
          default: queue_u(16'($urandom_range(16'h0800, 16'hFFFF)));
        endcase
      end else if (pick < 60) begin
        queue_u(random_high());
        queue_u(random_low());
      end else if (pick < 67) begin
        queue_u(random_high());
        queue_after_high();
      end else if (pick < 70) begin
        queue_u(random_low());
      end else if (pick < 74) begin
        queue_text(CH_BSLASH);
        queue_text(bad_escape());
      end else if (pick < 78) begin
        if ($urandom_range(0, 1)) queue_u(random_high());
        queue_partial_u();
        queue_text(non_hex());
      end else if (pick < 85) begin
        queue_text(CH_QUOTE);
      end else if (pick < 90) begin
        case ($urandom_range(0, 4))
          0: ;
          1: queue_text(CH_BSLASH);
          2: queue_partial_u();
          3: queue_u(random_high());
          default: begin
            queue_u(random_high());
            queue_text(CH_BSLASH);
          end
        endcase
        queue_text(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) queue_text(noise_byte());
      end
    end
  endtask

  // text driver, bursts with random gaps

  always @(negedge clk) begin
    if (!rst) begin
      if (text_taken) void'(text_queue.pop_front());
      if (text_valid && !text_taken) begin
        // stalled transaction holds its payload
      end else if (gap_left > 0) begin
        gap_left--;
        text_valid <= 1'b0;
      end else if (text_queue.size() == 0 ||
                   (text_queue[0].drain && decoded_due.size() != 0)) begin
        text_valid <= 1'b0;
      end else begin
        text_valid <= 1'b1;
        text_byte  <= text_queue[0].ch;
        text_end   <= text_queue[0].fin;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // result stall pattern

  always @(negedge clk) begin
    if (rx_phase == 6'd0) rx_mode = $urandom_range(0, 3);
    rx_phase = rx_phase + 6'd1;
    case (rx_mode)
      0:       result_stall <= 1'b0;
      1:       result_stall <= ($urandom_range(0, 3) == 0);
      2:       result_stall <= ($urandom_range(0, 3) != 0);
      default: result_stall <= rx_phase[2];
    endcase
  end

  // transaction monitor and checker

  always @(posedge clk) begin
    text_taken <= !rst && text_valid && !text_stall;
    if (!rst) begin
      if (text_valid && !text_stall) decode_text(text_byte, text_end);
      if (result_valid && !result_stall) begin
        if (decoded_due.size() == 0) begin
          $error("result with nothing expected: out_byte %h result_kind %0d error_code %0d",
                 out_byte, result_kind, error_code);
          fail_count++;
        end else begin
          want = decoded_due.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte expected %h got %h", want.data, out_byte);
            fail_count++;
          end
          if (result_kind !== want.kind) begin
            $error("result_kind expected %0d got %0d", want.kind, result_kind);
            fail_count++;
          end
          if (error_code !== want.err) begin
            $error("error_code expected %0d got %0d", want.err, error_code);
            fail_count++;
          end
          if (last !== want.lst) begin
            $error("last expected %0d got %0d", want.lst, last);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    load_directed();
    load_random();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    while (text_queue.size() != 0 || text_valid) @(negedge clk);
    while (decoded_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && decoded_due.size() == 0)
      $display("json_string_unescape_utf8_tb: PASS");
    else
      $display("json_string_unescape_utf8_tb: FAIL");
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("json_string_unescape_utf8_tb: FAIL");
    $finish;
  end

endmodule
